>>> hdl/expiring_transaction_table_defines.svh
// Assertion shorthands for the expiring transaction table checkers.
`ifndef EXPIRING_TRANSACTION_TABLE_DEFINES_SVH
`define EXPIRING_TRANSACTION_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ETT_ASSERT_IMPLY(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("implication check failed");

// Next-cycle implication.
`define ETT_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/ett_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ett_pkg;

   localparam int HASH_ENTRIES_DEFAULT = 16;
   localparam int TAG_ENTRIES_DEFAULT  = 16;

   localparam logic [47:0] TIMEOUT_RESET    = 48'd5000;
   localparam logic [47:0] ABSENT_AGE_RESET = 48'd600000;

   localparam int CSR_ADDR_W = 4;

   // commands
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_COLLIDE   = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [47:0] now;
      logic [31:0] hash;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] time_value;
      logic [15:0] tag_value;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [47:0] stamp;
      logic [15:0] owner;
   } hash_entry_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] key;
      logic [47:0] stamp;
   } tag_entry_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PASS1,
      FSM_PASS2
   } fsm_type;

endpackage

`default_nettype wire

>>> hdl/ett_hash_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the hash ring; takes its neighbor's entry on each shift.
module ett_hash_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    shift,
   input  wire ett_pkg::hash_entry_type d,
   output ett_pkg::hash_entry_type      q
);

   logic        valid_ff;
   logic [31:0] key_ff;
   logic [47:0] stamp_ff;
   logic [15:0] owner_ff;

   // valid bit is control, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= d.key;
         stamp_ff <= d.stamp;
         owner_ff <= d.owner;
      end
   end

   assign q = '{valid: valid_ff, key: key_ff, stamp: stamp_ff, owner: owner_ff};

endmodule

`default_nettype wire

>>> hdl/ett_tag_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the tag ring; takes its neighbor's entry on each shift.
module ett_tag_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift,
   input  wire ett_pkg::tag_entry_type d,
   output ett_pkg::tag_entry_type      q
);

   logic        valid_ff;
   logic [15:0] key_ff;
   logic [47:0] stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= d.key;
         stamp_ff <= d.stamp;
      end
   end

   assign q = '{valid: valid_ff, key: key_ff, stamp: stamp_ff};

endmodule

`default_nettype wire

>>> hdl/expiring_transaction_table.sv
// A command runs one rotation of both rings (PASS1), L = max(HASH_ENTRIES, TAG_ENTRIES) slots,
// then registers the rsp_valid strobe; an insert that is taken needs a second rotation (PASS2).
// The block takes no new command while busy; start is taken again in the cycle the strobe shows.
// During a pass each ring rotates one slot per cycle past its own head unit until every slot is seen.
// Results cannot be stalled. Synchronous reset clears all valid bits and the control registers.
`timescale 1ns / 1ps
`default_nettype none

module expiring_transaction_table #(
   parameter int HASH_ENTRIES = ett_pkg::HASH_ENTRIES_DEFAULT,
   parameter int TAG_ENTRIES  = ett_pkg::TAG_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire ett_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   output ett_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ett_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [63:0]                       pwdata,
   output logic [63:0]                            prdata,
   output logic                                   pready
);

   localparam int L    = (HASH_ENTRIES > TAG_ENTRIES) ? HASH_ENTRIES : TAG_ENTRIES;
   localparam int CW   = (L > 1) ? $clog2(L) : 1;
   localparam int CNTW = $clog2(HASH_ENTRIES + 1);

   typedef struct packed {
      logic hfound;
      logic hcollide;
      logic hfree;
      logic tfound;
      logic tfree;
      logic hwritten;
      logic twritten;
   } flags_type;

   ett_pkg::fsm_type state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   ett_pkg::req_type req_ff, req_in;
   logic [47:0]      limit_ff, limit_in;
   logic             expire_en_ff, expire_en_in;
   flags_type        flags_ff, flags_in;
   logic [47:0]      cap_time_ff, cap_time_in;
   logic [15:0]      cap_owner_ff, cap_owner_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ett_pkg::rsp_type rsp_ff, rsp_in;
   logic [47:0]      timeout_ff, timeout_in;
   logic [47:0]      absent_ff, absent_in;

   ett_pkg::hash_entry_type hash_q [HASH_ENTRIES];
   ett_pkg::tag_entry_type  tag_q  [TAG_ENTRIES];
   ett_pkg::hash_entry_type hash_head;
   ett_pkg::tag_entry_type  tag_head;
   logic hash_shift, tag_shift;

   // hash ring: slot 0 passes through the head unit into the last slot
   for (genvar i = 0; i < HASH_ENTRIES; i++) begin : g_hash
      if (i == HASH_ENTRIES - 1) begin : g_last
         ett_hash_cell u_cell (.clock, .reset, .shift(hash_shift), .d(hash_head),
                               .q(hash_q[i]));
      end else begin : g_mid
         ett_hash_cell u_cell (.clock, .reset, .shift(hash_shift), .d(hash_q[i+1]),
                               .q(hash_q[i]));
      end
   end

   // tag ring
   for (genvar i = 0; i < TAG_ENTRIES; i++) begin : g_tag
      if (i == TAG_ENTRIES - 1) begin : g_last
         ett_tag_cell u_cell (.clock, .reset, .shift(tag_shift), .d(tag_head),
                              .q(tag_q[i]));
      end else begin : g_mid
         ett_tag_cell u_cell (.clock, .reset, .shift(tag_shift), .d(tag_q[i+1]),
                              .q(tag_q[i]));
      end
   end

   // CSR access
   logic csr_wr;
   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign prdata = paddr[3] ? {16'b0, absent_ff} : {16'b0, timeout_ff};

   always_comb begin
      timeout_in = timeout_ff;
      absent_in  = absent_ff;
      if (csr_wr) begin
         if (paddr[3]) begin
            absent_in = pwdata[47:0];
         end else begin
            timeout_in = pwdata[47:0];
         end
      end
   end

   // sequencer and head units
   always_comb begin
      logic        is_p1, is_p2, last, exp_cmd, hv, hit, tv, thit, full;
      logic [CNTW+4:0] cnt_ext;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      limit_in     = limit_ff;
      expire_en_in = expire_en_ff;
      flags_in     = flags_ff;
      cap_time_in  = cap_time_ff;
      cap_owner_in = cap_owner_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      hash_head    = hash_q[0];
      tag_head     = tag_q[0];
      hv           = 1'b0;
      hit          = 1'b0;
      tv           = 1'b0;
      thit         = 1'b0;
      full         = 1'b0;
      cnt_ext      = '0;

      is_p1   = (state_ff == ett_pkg::FSM_PASS1);
      is_p2   = (state_ff == ett_pkg::FSM_PASS2);
      last    = (cnt_ff == CW'(L - 1));
      exp_cmd = (req_ff.cmd == ett_pkg::CMD_INSERT) || (req_ff.cmd == ett_pkg::CMD_REMOVE);

      hash_shift = (is_p1 | is_p2) && ({1'b0, cnt_ff} < (CW+1)'(HASH_ENTRIES));
      tag_shift  = (is_p1 | is_p2) && ({1'b0, cnt_ff} < (CW+1)'(TAG_ENTRIES));

      // hash head: search, expire, erase, fill
      if (hash_shift && is_p1) begin
         hv  = hash_q[0].valid;
         // match taken before expiry: a remove still finds a stale entry
         hit = hv && (hash_q[0].key == req_ff.hash);
         if (exp_cmd && expire_en_ff && hv && (hash_q[0].stamp <= limit_ff)) begin
            hv = 1'b0;
         end
         case (req_ff.cmd)
            ett_pkg::CMD_INSERT: begin
               if (hit && hv) flags_in.hcollide = 1'b1;
               if (!hv) flags_in.hfree = 1'b1;
            end
            ett_pkg::CMD_LOOKUP: begin
               if (hit) begin
                  flags_in.hfound = 1'b1;
                  cap_time_in     = hash_q[0].stamp;
                  cap_owner_in    = hash_q[0].owner;
               end
            end
            ett_pkg::CMD_REMOVE: begin
               if (hit) begin
                  flags_in.hfound = 1'b1;
                  hv              = 1'b0;
               end
            end
            default: ;
         endcase
         hash_head.valid = hv;
         count_in = count_ff + CNTW'(hv);
      end
      if (hash_shift && is_p2 && !hash_q[0].valid && !flags_ff.hwritten) begin
         hash_head.valid   = 1'b1;
         hash_head.key     = req_ff.hash;
         hash_head.stamp   = req_ff.now;
         hash_head.owner   = req_ff.tag;
         flags_in.hwritten = 1'b1;
         count_in          = count_ff + CNTW'(1);
      end

      // tag head: expire, search, refresh, fill
      if (tag_shift && is_p1) begin
         tv = tag_q[0].valid;
         if (exp_cmd && expire_en_ff && tv && (tag_q[0].stamp <= limit_ff)) begin
            tv = 1'b0;
         end
         thit = tv && (tag_q[0].key == req_ff.tag);
         case (req_ff.cmd)
            ett_pkg::CMD_INSERT: begin
               if (thit) flags_in.tfound = 1'b1;
               if (!tv) flags_in.tfree = 1'b1;
            end
            ett_pkg::CMD_QUERY: begin
               if (thit) begin
                  flags_in.tfound = 1'b1;
                  cap_time_in     = tag_q[0].stamp;
               end
            end
            default: ;
         endcase
         tag_head.valid = tv;
      end
      if (tag_shift && is_p2) begin
         if (flags_ff.tfound) begin
            if (tag_q[0].valid && (tag_q[0].key == req_ff.tag)) begin
               tag_head.stamp = req_ff.now;
            end
         end else if (!tag_q[0].valid && !flags_ff.twritten) begin
            tag_head.valid    = 1'b1;
            tag_head.key      = req_ff.tag;
            tag_head.stamp    = req_ff.now;
            flags_in.twritten = 1'b1;
         end
      end

      cnt_ext = {5'b0, count_in};

      // next state and result
      case (state_ff)
         ett_pkg::FSM_IDLE: begin
            if (start) begin
               state_in     = ett_pkg::FSM_PASS1;
               cnt_in       = '0;
               req_in       = req_data;
               expire_en_in = (req_data.now >= timeout_ff);
               limit_in     = req_data.now - timeout_ff;
               flags_in     = '0;
               count_in     = '0;
               cap_time_in  = '0;
               cap_owner_in = '0;
            end
         end
         ett_pkg::FSM_PASS1: begin
            cnt_in = cnt_ff + CW'(1);
            if (last) begin
               cnt_in             = '0;
               rsp_in             = '0;
               rsp_in.entry_count = cnt_ext[4:0];
               rsp_valid_in       = 1'b1;
               state_in           = ett_pkg::FSM_IDLE;
               full = !flags_in.hfree || (!flags_in.tfound && !flags_in.tfree);
               case (req_ff.cmd)
                  ett_pkg::CMD_INSERT: begin
                     if (full) begin
                        rsp_in.status = ett_pkg::ST_FULL;
                     end else if (flags_in.hcollide) begin
                        rsp_in.status = ett_pkg::ST_COLLIDE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ett_pkg::FSM_PASS2;
                     end
                  end
                  ett_pkg::CMD_LOOKUP: begin
                     if (flags_in.hfound) begin
                        rsp_in.status     = ett_pkg::ST_OK;
                        rsp_in.time_value = cap_time_in;
                        rsp_in.tag_value  = cap_owner_in;
                     end else begin
                        rsp_in.status = ett_pkg::ST_NOT_FOUND;
                     end
                  end
                  ett_pkg::CMD_REMOVE: begin
                     rsp_in.status = flags_in.hfound ? ett_pkg::ST_OK : ett_pkg::ST_NOT_FOUND;
                  end
                  default: begin
                     if (flags_in.tfound) begin
                        rsp_in.status     = ett_pkg::ST_OK;
                        rsp_in.time_value = cap_time_in;
                     end else begin
                        rsp_in.status     = ett_pkg::ST_NOT_FOUND;
                        rsp_in.time_value = (req_ff.now >= absent_ff) ?
                                            req_ff.now - absent_ff : 48'd0;
                     end
                  end
               endcase
            end
         end
         ett_pkg::FSM_PASS2: begin
            cnt_in = cnt_ff + CW'(1);
            if (last) begin
               cnt_in             = '0;
               rsp_in             = '0;
               rsp_in.status      = ett_pkg::ST_OK;
               rsp_in.entry_count = cnt_ext[4:0];
               rsp_valid_in       = 1'b1;
               state_in           = ett_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = ett_pkg::FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ett_pkg::FSM_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         count_ff     <= '0;
         timeout_ff   <= ett_pkg::TIMEOUT_RESET;
         absent_ff    <= ett_pkg::ABSENT_AGE_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         timeout_ff   <= timeout_in;
         absent_ff    <= absent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      limit_ff     <= limit_in;
      expire_en_ff <= expire_en_in;
      cap_time_ff  <= cap_time_in;
      cap_owner_ff <= cap_owner_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ett_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> hdl/ett_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "expiring_transaction_table_defines.svh"

// Port-level checks on the command handshake and result strobe.
module ett_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire ett_pkg::rsp_type rsp_data,
   input wire logic             pready
);

   // an accepted beat keeps the block busy next cycle
   `ETT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

   // a result strobe lasts one cycle and frees the block
   `ETT_ASSERT_NEXT(a_strobe_pulse, rsp_valid, !rsp_valid)
   `ETT_ASSERT_IMPLY(a_idle_on_result, rsp_valid, !busy)

   // live count never exceeds table depth at the default size
   `ETT_ASSERT_IMPLY(a_count_range, rsp_valid && pready, rsp_data.entry_count <= 5'd16)

endmodule

bind expiring_transaction_table ett_checker u_ett_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HASH_SLOTS = ett_pkg::HASH_ENTRIES_DEFAULT;
   localparam int TAG_SLOTS  = ett_pkg::TAG_ENTRIES_DEFAULT;
   localparam logic [ett_pkg::CSR_ADDR_W-1:0] REG_TIMEOUT    = 4'd0;
   localparam logic [ett_pkg::CSR_ADDR_W-1:0] REG_ABSENT_AGE = 4'd8;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 125;

   // Shadow of both tables; predicts one response per command beat.
   class table_scoreboard;
      logic [47:0] timeout_ms;
      logic [47:0] absent_ms;
      bit          hvalid[HASH_SLOTS];
      logic [31:0] hkey[HASH_SLOTS];
      logic [47:0] htime[HASH_SLOTS];
      logic [15:0] howner[HASH_SLOTS];
      bit          tvalid[TAG_SLOTS];
      logic [15:0] tkey[TAG_SLOTS];
      logic [47:0] ttime[TAG_SLOTS];
      ett_pkg::rsp_type pending[$];
      int          mismatches;

      function new();
         timeout_ms = ett_pkg::TIMEOUT_RESET;
         absent_ms  = ett_pkg::ABSENT_AGE_RESET;
         mismatches = 0;
         foreach (hvalid[i]) hvalid[i] = 1'b0;
         foreach (tvalid[i]) tvalid[i] = 1'b0;
      endfunction

      function void set_register(logic [ett_pkg::CSR_ADDR_W-1:0] addr, logic [47:0] value);
         case (addr)
            REG_TIMEOUT:    timeout_ms = value;
            REG_ABSENT_AGE: absent_ms  = value;
            default: ;
         endcase
      endfunction

      // Drop every entry stamped at or below now - timeout, unless now is below timeout.
      function void expire(logic [47:0] now);
         logic [47:0] cutoff;
         if (now < timeout_ms) return;
         cutoff = now - timeout_ms;
         foreach (hvalid[i]) if (hvalid[i] && htime[i] <= cutoff) hvalid[i] = 1'b0;
         foreach (tvalid[i]) if (tvalid[i] && ttime[i] <= cutoff) tvalid[i] = 1'b0;
      endfunction

      function int find_hash(logic [31:0] h);
         foreach (hvalid[i]) if (hvalid[i] && hkey[i] == h) return i;
         return -1;
      endfunction

      function int find_tag(logic [15:0] t);
         foreach (tvalid[i]) if (tvalid[i] && tkey[i] == t) return i;
         return -1;
      endfunction

      function void note_request(ett_pkg::req_type r);
         ett_pkg::rsp_type exp;
         int hs, ts, hfree, tfree, n;
         exp = '0;
         case (r.cmd)
            ett_pkg::CMD_INSERT: begin
               expire(r.now);
               ts = find_tag(r.tag);
               hfree = -1;
               tfree = -1;
               for (int i = HASH_SLOTS - 1; i >= 0; i--) if (!hvalid[i]) hfree = i;
               for (int i = TAG_SLOTS - 1; i >= 0; i--) if (!tvalid[i]) tfree = i;
               if (hfree < 0 || (ts < 0 && tfree < 0)) begin
                  exp.status = ett_pkg::ST_FULL;
               end else if (find_hash(r.hash) >= 0) begin
                  exp.status = ett_pkg::ST_COLLIDE;
               end else begin
                  hvalid[hfree] = 1'b1;
                  hkey[hfree]   = r.hash;
                  htime[hfree]  = r.now;
                  howner[hfree] = r.tag;
                  if (ts < 0) begin
                     ts = tfree;
                     tvalid[ts] = 1'b1;
                     tkey[ts]   = r.tag;
                  end
                  ttime[ts] = r.now;
               end
            end
            ett_pkg::CMD_LOOKUP: begin
               hs = find_hash(r.hash);
               if (hs >= 0) begin
                  exp.time_value = htime[hs];
                  exp.tag_value  = howner[hs];
               end else begin
                  exp.status = ett_pkg::ST_NOT_FOUND;
               end
            end
            ett_pkg::CMD_REMOVE: begin
               hs = find_hash(r.hash);
               if (hs >= 0) hvalid[hs] = 1'b0;
               else exp.status = ett_pkg::ST_NOT_FOUND;
               expire(r.now);
            end
            default: begin
               ts = find_tag(r.tag);
               if (ts >= 0) begin
                  exp.time_value = ttime[ts];
               end else begin
                  exp.status = ett_pkg::ST_NOT_FOUND;
                  exp.time_value = (r.now >= absent_ms) ? r.now - absent_ms : 48'd0;
               end
            end
         endcase
         n = 0;
         foreach (hvalid[i]) if (hvalid[i]) n++;
         exp.entry_count = n[4:0];
         pending.push_back(exp);
      endfunction

      function void check_response(ett_pkg::rsp_type got);
         ett_pkg::rsp_type exp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: %p", got);
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status || got.time_value !== exp.time_value ||
             got.tag_value !== exp.tag_value || got.entry_count !== exp.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: status %0d/%0d time %0d/%0d tag %0h/%0h count %0d/%0d",
                        exp.status, got.status, exp.time_value, got.time_value,
                        exp.tag_value, got.tag_value, exp.entry_count, got.entry_count);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   ett_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   ett_pkg::rsp_type               rsp_data;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [ett_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0]                    pwdata = '0;
   logic [63:0]                    prdata;
   logic                           pready;

   table_scoreboard sb = new();
   int          cycles = 0;
   int          idle_pct = 0;
   logic [47:0] now_ms = '0;
   logic [31:0] hash_pool[24];
   logic [15:0] tag_pool[20];

   expiring_transaction_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("expiring_transaction_table test failed");
         $finish;
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_command(logic [1:0] cmd, logic [47:0] now, logic [31:0] h,
                               logic [15:0] t);
      ett_pkg::req_type r;
      r.cmd = cmd;
      r.now = now;
      r.hash = h;
      r.tag = t;
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      // busy is stable at the falling edge, so a raised start is taken at the next rise
      while (busy) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic csr_write(logic [ett_pkg::CSR_ADDR_W-1:0] addr, logic [47:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = {16'd0, value};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(addr, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // Mostly pooled hashes and tags so hits, collisions and full tables occur.
   task automatic send_random(logic [47:0] step);
      logic [1:0]  cmd;
      logic [31:0] h;
      logic [15:0] t;
      int          pick;
      pick = $urandom_range(0, 99);
      cmd = (pick < 40) ? ett_pkg::CMD_INSERT : (pick < 60) ? ett_pkg::CMD_LOOKUP :
            (pick < 80) ? ett_pkg::CMD_REMOVE : ett_pkg::CMD_QUERY;
      h = ($urandom_range(0, 9) == 0) ? $urandom : hash_pool[$urandom_range(0, 23)];
      t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tag_pool[$urandom_range(0, 19)];
      if ($urandom_range(0, 49) == 0 && now_ms > 48'd100)
         now_ms = now_ms - 48'($urandom_range(1, 100));
      else
         now_ms = now_ms + 48'($urandom_range(0, int'(step)));
      send_command(cmd, now_ms, h, t);
   endtask

   initial begin
      logic [47:0] phase_timeout[PHASES];
      logic [47:0] phase_absent[PHASES];
      int          phase_idle[4];
      logic [47:0] step;

      foreach (hash_pool[i]) hash_pool[i] = $urandom;
      foreach (tag_pool[i]) tag_pool[i] = 16'($urandom);
      phase_timeout = '{48'd200, 48'd0, TIME_MAX, 48'($urandom_range(1000, 9000)), 48'd1,
                        48'd100};
      phase_absent  = '{48'd1000, 48'd0, TIME_MAX, {16'($urandom), 32'($urandom)}, 48'd500,
                        48'd30};
      phase_idle    = '{0, 51, 0, 27};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings
      send_command(ett_pkg::CMD_QUERY, 48'd0, 32'd0, 16'h0001);   // unknown tag saturates
      send_command(ett_pkg::CMD_INSERT, 48'd10, 32'h0000_0001, 16'h0001);
      send_command(ett_pkg::CMD_INSERT, 48'd11, 32'h0000_0001, 16'h0002); // collision
      send_command(ett_pkg::CMD_LOOKUP, 48'd12, 32'h0000_0001, 16'h0000);
      send_command(ett_pkg::CMD_LOOKUP, 48'd12, 32'h0000_0002, 16'h0000); // miss
      send_command(ett_pkg::CMD_QUERY, 48'd13, 32'd0, 16'h0001);
      send_command(ett_pkg::CMD_REMOVE, 48'd14, 32'h0000_0001, 16'h0000);
      send_command(ett_pkg::CMD_REMOVE, 48'd15, 32'h0000_0001, 16'h0000); // remove miss
      // fill the hash table, then one more is refused
      for (int i = 0; i < HASH_SLOTS + 1; i++)
         send_command(ett_pkg::CMD_INSERT, 48'd100 + 48'(i), 32'h8000_0000 | 32'(i),
                      16'h00F0);
      send_command(ett_pkg::CMD_INSERT, 48'd5100, 32'h1234_5678, 16'hA5A5); // expiry boundary
      send_command(ett_pkg::CMD_INSERT, 48'd5000, 32'h1234_5679, 16'hA5A5); // time backwards
      send_command(ett_pkg::CMD_QUERY, TIME_MAX, 32'd0, 16'h5A5A);   // unknown tag, large now
      send_command(ett_pkg::CMD_INSERT, TIME_MAX, 32'hFFFF_FFFF, 16'hFFFF); // sweeps all
      send_command(ett_pkg::CMD_LOOKUP, TIME_MAX, 32'hFFFF_FFFF, 16'h0000);
      send_command(ett_pkg::CMD_REMOVE, TIME_MAX, 32'hFFFF_FFFF, 16'h0000);

      // Random phases, each with its own settings, and idling taken from a list of four
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (DRAIN_CYCLES) @(negedge clock);
         csr_write(REG_TIMEOUT, phase_timeout[p]);
         csr_write(REG_ABSENT_AGE, phase_absent[p]);
         idle_pct = phase_idle[p % 4];
         now_ms = 48'($urandom_range(0, 1000));
         step = (phase_timeout[p] > 48'd400) ? 48'd100 : phase_timeout[p] / 4 + 48'd1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == PHASE_ITEMS / 2) wait_drained();
            // no-idle stretch in the middle of every phase
            if (i == PHASE_ITEMS / 3) idle_pct = 0;
            if (i == 2 * PHASE_ITEMS / 3) idle_pct = phase_idle[p % 4];
            send_random(step);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("expiring_transaction_table test passed");
      else
         $display("expiring_transaction_table test failed");
      $finish;
   end

endmodule
